// ===== sv/prx_pkg.sv =====
// ----------------------------------------------------------------------------
// prx_pkg
// Shared types and constants of the printable run extractor.
// ----------------------------------------------------------------------------
package prx_pkg;

  // Scan modes held in the scan mode register.
  typedef enum logic [1:0] {
    MODE_ASCII    = 2'd0,
    MODE_UTF16LE  = 2'd1,
    MODE_UTF16BE  = 2'd2
  } prx_mode_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SCAN_MODE  = 2'd0;
  localparam logic [1:0] CFG_MIN_LENGTH = 2'd1;

  // Character classes.
  localparam logic [7:0] CHAR_FIRST_PRINT = 8'h20;
  localparam logic [7:0] CHAR_LAST_PRINT  = 8'h7E;
  localparam logic [7:0] CHAR_TAB         = 8'h09;
  localparam logic [7:0] CHAR_NUL         = 8'h00;

  // Tail of one result burst: the current character and the end marker.
  typedef struct packed {
    logic [7:0] chr;
    logic       emit_char;
    logic       emit_end;
  } prx_tail_t;

  function automatic logic is_printable(input logic [7:0] c);
    is_printable = (c >= CHAR_FIRST_PRINT) && (c <= CHAR_LAST_PRINT);
  endfunction

endpackage

// ===== sv/prx_in_if.sv =====
// ----------------------------------------------------------------------------
// prx_in_if
// Input byte channel: one raw stream byte per beat.
// ----------------------------------------------------------------------------
interface prx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source(output valid, data_byte, end_of_file, input ready);
  modport sink(input valid, data_byte, end_of_file, output ready);
endinterface

// ===== sv/prx_out_if.sv =====
// ----------------------------------------------------------------------------
// prx_out_if
// Result channel: one extracted character or end marker per beat.
// ----------------------------------------------------------------------------
interface prx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       is_end_marker;
  logic       last_of_burst;

  modport source(output valid, out_char, is_end_marker, last_of_burst, input ready);
  modport sink(input valid, out_char, is_end_marker, last_of_burst, output ready);
endinterface

// ===== sv/prx_cfg_if.sv =====
// ----------------------------------------------------------------------------
// prx_cfg_if
// Configuration write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface prx_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/prx_emit.sv =====
// ----------------------------------------------------------------------------
// prx_emit
// Result sequencer: holds the head characters of the open run and plays
// out the results of one byte, one beat per cycle while the port is ready.
// ----------------------------------------------------------------------------
module prx_emit #(
  parameter int MAX_MIN_LENGTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Head store write port.
  input  logic                              hwr_en_i,
  input  logic [$clog2(MAX_MIN_LENGTH)-1:0] hwr_idx_i,
  input  logic [7:0]                        hwr_data_i,
  // New burst from the decode logic.
  input  logic                              load_i,
  input  logic [$clog2(MAX_MIN_LENGTH)-1:0] head_cnt_i,
  input  prx_pkg::prx_tail_t                tail_i,
  output logic                              can_load_o,
  prx_out_if.source                         out_o
);

  localparam int HIW = $clog2(MAX_MIN_LENGTH);

  logic [7:0]     head_q [MAX_MIN_LENGTH];
  logic [HIW-1:0] head_left_q, head_left_d;
  logic [HIW-1:0] hidx_q, hidx_d;
  logic [7:0]     chr_q, chr_d;
  logic           char_pend_q, char_pend_d;
  logic           end_pend_q, end_pend_d;
  logic           head_busy;
  logic           busy;
  logic           last;
  logic           fire;

  // Head characters of the open run; entries are written before they are read.
  always_ff @(posedge clk_i) begin
    if (hwr_en_i) begin
      head_q[hwr_idx_i] <= hwr_data_i;
    end
  end

  assign head_busy = (head_left_q != '0);
  assign busy      = head_busy || char_pend_q || end_pend_q;

  // The beat on the port is the last one of its burst.
  always_comb begin
    if (!head_busy) begin
      last = !(char_pend_q && end_pend_q);
    end else if (head_left_q == HIW'(1)) begin
      last = !char_pend_q && !end_pend_q;
    end else begin
      last = 1'b0;
    end
  end

  // Output beat selection: head characters, then the character, then the marker.
  always_comb begin
    out_o.valid         = busy;
    out_o.last_of_burst = last;
    out_o.is_end_marker = 1'b0;
    if (head_busy) begin
      out_o.out_char = head_q[hidx_q];
    end else if (char_pend_q) begin
      out_o.out_char = chr_q;
    end else begin
      out_o.out_char      = prx_pkg::CHAR_NUL;
      out_o.is_end_marker = end_pend_q;
    end
  end

  assign fire       = busy && out_o.ready;
  assign can_load_o = !busy || (fire && last);

  // Burst bookkeeping.
  always_comb begin
    head_left_d = head_left_q;
    hidx_d      = hidx_q;
    chr_d       = chr_q;
    char_pend_d = char_pend_q;
    end_pend_d  = end_pend_q;
    if (load_i) begin
      head_left_d = head_cnt_i;
      hidx_d      = '0;
      chr_d       = tail_i.chr;
      char_pend_d = tail_i.emit_char;
      end_pend_d  = tail_i.emit_end;
    end else if (fire) begin
      if (head_busy) begin
        head_left_d = head_left_q - HIW'(1);
        hidx_d      = hidx_q + HIW'(1);
      end else if (char_pend_q) begin
        char_pend_d = 1'b0;
      end else begin
        end_pend_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_left_q <= '0;
      hidx_q      <= '0;
      char_pend_q <= 1'b0;
      end_pend_q  <= 1'b0;
    end else begin
      head_left_q <= head_left_d;
      hidx_q      <= hidx_d;
      char_pend_q <= char_pend_d;
      end_pend_q  <= end_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chr_q <= chr_d;
  end

endmodule

// ===== sv/printable_run_extractor.sv =====
// ----------------------------------------------------------------------------
// printable_run_extractor
// Finds runs of printable characters in a byte stream (ASCII or UTF-16).
// ----------------------------------------------------------------------------
// The block takes one stream byte per beat and reports runs of printable
// characters that reach the programmed minimum length, each run closed by an
// end marker beat. A byte that yields at most one result is taken every
// cycle while the output is ready. The byte that completes the minimum
// length yields the held head characters plus itself (up to MAX_MIN_LENGTH
// beats, one more with an end of file marker); the result sequencer plays
// these out one beat per cycle while the output is ready and takes the next
// byte in the cycle of the final beat. No clearing pass runs after reset.
module printable_run_extractor #(
  parameter int MAX_RUN_CHARS  = 1024,
  parameter int MAX_MIN_LENGTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  prx_cfg_if.sink     cfg_i,
  prx_in_if.sink      in_i,
  prx_out_if.source   out_o
);

  localparam int RLW = $clog2(MAX_RUN_CHARS);
  localparam int MLW = $clog2(MAX_MIN_LENGTH + 1);
  localparam int HIW = $clog2(MAX_MIN_LENGTH);
  localparam int CW  = ((RLW > MLW) ? RLW : MLW) + 1;

  logic [1:0]     scan_mode_q;
  logic [4:0]     min_length_q;
  logic [7:0]     pend_byte_q, pend_byte_d;
  logic           pend_valid_q, pend_valid_d;
  logic [RLW-1:0] run_len_q;
  logic [CW-1:0]  run_d;
  logic [CW-1:0]  run_ext;
  logic [CW-1:0]  new_len;
  logic [CW-1:0]  min_ext;
  logic [CW-1:0]  eff_min;
  logic           can_take;
  logic           take;
  logic           close;
  logic [7:0]     take_chr;
  logic           match;
  logic           accept;
  logic           can_load;
  logic           hwr_en;
  logic [HIW-1:0] head_cnt;
  prx_pkg::prx_tail_t tail;

  // Configuration registers; writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_mode_q  <= prx_pkg::MODE_ASCII;
      min_length_q <= 5'd4;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == prx_pkg::CFG_SCAN_MODE) begin
        scan_mode_q <= cfg_i.data[1:0];
      end else if (cfg_i.index == prx_pkg::CFG_MIN_LENGTH) begin
        min_length_q <= cfg_i.data[4:0];
      end
    end
  end

  // Effective minimum length: zero reads as one, large values saturate.
  assign min_ext = CW'(min_length_q);
  always_comb begin
    if (min_ext == '0) begin
      eff_min = CW'(1);
    end else if (min_ext > CW'(MAX_MIN_LENGTH)) begin
      eff_min = CW'(MAX_MIN_LENGTH);
    end else begin
      eff_min = min_ext;
    end
  end

  assign run_ext  = CW'(run_len_q);
  assign new_len  = run_ext + CW'(1);
  assign can_take = run_ext < CW'(MAX_RUN_CHARS - 1);

  // Byte decode: does this byte complete a character or break the run.
  always_comb begin
    take         = 1'b0;
    close        = 1'b0;
    take_chr     = in_i.data_byte;
    match        = 1'b0;
    pend_byte_d  = pend_byte_q;
    pend_valid_d = pend_valid_q;
    unique case (scan_mode_q)
      prx_pkg::MODE_UTF16LE, prx_pkg::MODE_UTF16BE: begin
        if (scan_mode_q == prx_pkg::MODE_UTF16LE) begin
          match    = prx_pkg::is_printable(pend_byte_q) &&
                     (in_i.data_byte == prx_pkg::CHAR_NUL);
          take_chr = pend_byte_q;
        end else begin
          match    = (pend_byte_q == prx_pkg::CHAR_NUL) &&
                     prx_pkg::is_printable(in_i.data_byte);
          take_chr = in_i.data_byte;
        end
        if (!pend_valid_q) begin
          pend_byte_d  = in_i.data_byte;
          pend_valid_d = 1'b1;
        end else if (match) begin
          take         = 1'b1;
          pend_byte_d  = prx_pkg::CHAR_NUL;
          pend_valid_d = 1'b0;
        end else begin
          close        = 1'b1;
          pend_byte_d  = in_i.data_byte;
          pend_valid_d = 1'b1;
        end
      end
      default: begin
        pend_byte_d  = prx_pkg::CHAR_NUL;
        pend_valid_d = 1'b0;
        if (prx_pkg::is_printable(in_i.data_byte) ||
            (in_i.data_byte == prx_pkg::CHAR_TAB)) begin
          take = 1'b1;
        end else begin
          close = 1'b1;
        end
      end
    endcase
    if (in_i.end_of_file) begin
      pend_byte_d  = prx_pkg::CHAR_NUL;
      pend_valid_d = 1'b0;
    end
  end

  // Run bookkeeping and the burst that this byte causes.
  always_comb begin
    run_d          = run_ext;
    hwr_en         = 1'b0;
    head_cnt       = '0;
    tail.chr       = take_chr;
    tail.emit_char = 1'b0;
    tail.emit_end  = 1'b0;
    if (take && can_take) begin
      run_d  = new_len;
      hwr_en = accept && (new_len <= CW'(MAX_MIN_LENGTH));
      if (new_len == eff_min) begin
        head_cnt       = HIW'(new_len - CW'(1));
        tail.emit_char = 1'b1;
      end else if (new_len > eff_min) begin
        tail.emit_char = 1'b1;
      end
    end
    if (close) begin
      tail.emit_end = run_ext >= eff_min;
      run_d         = '0;
    end
    // End of file closes whatever run is still open.
    if (in_i.end_of_file) begin
      if (run_d >= eff_min) begin
        tail.emit_end = 1'b1;
      end
      run_d = '0;
    end
  end

  assign in_i.ready = can_load;
  assign accept     = in_i.valid && can_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_byte_q  <= prx_pkg::CHAR_NUL;
      pend_valid_q <= 1'b0;
      run_len_q    <= '0;
    end else if (accept) begin
      pend_byte_q  <= pend_byte_d;
      pend_valid_q <= pend_valid_d;
      run_len_q    <= RLW'(run_d);
    end
  end

  // Result sequencer with the head character store.
  prx_emit #(
    .MAX_MIN_LENGTH(MAX_MIN_LENGTH)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .hwr_en_i   (hwr_en),
    .hwr_idx_i  (HIW'(new_len - CW'(1))),
    .hwr_data_i (take_chr),
    .load_i     (accept),
    .head_cnt_i (head_cnt),
    .tail_i     (tail),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule

// ===== sv/prx_checker.sv =====
// ----------------------------------------------------------------------------
// prx_checker
// Port level checks of the printable run extractor, bound to the top level.
// ----------------------------------------------------------------------------
module prx_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_end,
  input logic       out_last
);

  // A stalled result beat stays on the port.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // An end marker carries no character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_end |-> out_char == 8'h00)
    else $error("end marker with nonzero character");

  // The end marker is always the final beat of its burst.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_end |-> out_last)
    else $error("end marker not last of burst");

  // No new byte is taken while a burst still has more than one beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken in the middle of a burst");

endmodule

bind printable_run_extractor prx_checker u_prx_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_char  (out_o.out_char),
  .out_end   (out_o.is_end_marker),
  .out_last  (out_o.last_of_burst)
);
